FILE: rtl/lrc_pkg.sv
package lrc_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int CAP_W   = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] value_out;
        logic               evicted;
    } t_out_res;

endpackage

FILE: rtl/lru_lookup_cache.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall   i_in_req   (opcode, key, value)
// out       output     o_out_valid/i_out_stall o_out_res  (hit, value_out, evicted)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (capacity)
//
// Lookup: one key compare per cycle from the most recent entry, then one slot
// move per cycle on a hit to put the hit entry at slot 0. Insert: each kept
// entry moves one slot older, then the new entry goes to slot 0. All moves use
// the single key/value RAM port pair. Reset is synchronous and empties the
// cache by clearing the fill count; no clearing pass. A result waits in the
// output register under stall while the next request is already accepted.
module lru_lookup_cache #(
    parameter int ENTRIES    = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lrc_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lrc_pkg::t_out_res         o_out_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lrc_pkg::CAP_W-1:0] i_cfg_data
);

    import lrc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int DW    = KEY_BITS + VALUE_BITS;

    logic [CAP_W-1:0] r_capacity;
    logic             r_out_valid;
    t_out_res         r_out_res;

    logic             w_busy;
    logic             w_res_valid;
    logic             w_res_ready;
    t_out_res         w_res;
    logic [CNT_W-1:0] w_held;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [DW-1:0]    w_wr_data;
    logic [DW-1:0]    w_rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (w_res_valid && w_res_ready) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_res_valid && w_res_ready) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    lrc_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_req),
        .i_capacity  (r_capacity),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_busy      (w_busy),
        .o_held      (w_held),
        .o_rd_addr   (w_rd_addr),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    lrc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy next cycle");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_held) <= ENTRIES))
        else $error("fill count above entry count");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_out_valid)
        else $error("result handed over but output not valid");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> o_in_stall)
        else $error("result offered while accepting requests");
`endif

endmodule

FILE: rtl/lrc_ram.sv
module lrc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/lrc_ctrl.sv
module lrc_ctrl #(
    parameter int ENTRIES    = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1),
    localparam int DW    = KEY_BITS + VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  lrc_pkg::t_in_req              i_req,
    input  logic [lrc_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output lrc_pkg::t_out_res             o_res,
    output logic                          o_busy,
    output logic [CNT_W-1:0]              o_held,
    output logic [IDX_W-1:0]              o_rd_addr,
    output logic                          o_wr_en,
    output logic [IDX_W-1:0]              o_wr_addr,
    output logic [DW-1:0]                 o_wr_data,
    input  logic [DW-1:0]                 i_rd_data
);

    import lrc_pkg::*;

    // Entries sit in recency order: slot 0 is the most recent.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_last, n_last;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [DW-1:0]       r_entry, n_entry;
    logic                r_ins, n_ins;
    t_out_res            r_res, n_res;

    logic [CNT_W-1:0]    cap_u;
    logic [CNT_W-1:0]    keep_cnt;
    logic                key_match;

    always_comb begin
        if (i_capacity == '0) begin
            cap_u = CNT_W'(1);
        end else if (32'(i_capacity) > ENTRIES) begin
            cap_u = CNT_W'(ENTRIES);
        end else begin
            cap_u = CNT_W'(i_capacity);
        end
    end

    // Drop the oldest entries down to capacity - 1 before an insert.
    assign keep_cnt  = (r_held >= cap_u) ? (cap_u - CNT_W'(1)) : r_held;
    assign key_match = (i_rd_data[DW-1:VALUE_BITS] == r_key);

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_idx     = r_idx;
        n_last    = r_last;
        n_key     = r_key;
        n_entry   = r_entry;
        n_ins     = r_ins;
        n_res     = r_res;
        o_rd_addr = r_idx;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx + IDX_W'(1);
        o_wr_data = i_rd_data;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '0;
                    if (i_req.opcode == OP_LOOKUP) begin
                        n_key = i_req.key[KEY_BITS-1:0];
                        n_ins = 1'b0;
                        if (r_held == '0) begin
                            n_state = S_DONE;
                        end else begin
                            o_rd_addr = '0;
                            n_idx     = '0;
                            n_last    = IDX_W'(r_held - CNT_W'(1));
                            n_state   = S_SCAN;
                        end
                    end else begin
                        n_entry       = {i_req.key[KEY_BITS-1:0], i_req.value[VALUE_BITS-1:0]};
                        n_ins         = 1'b1;
                        n_res.evicted = (r_held >= cap_u);
                        n_held        = keep_cnt;
                        if (keep_cnt == '0) begin
                            n_state = S_PUT;
                        end else begin
                            o_rd_addr = IDX_W'(keep_cnt - CNT_W'(1));
                            n_idx     = IDX_W'(keep_cnt - CNT_W'(1));
                            n_state   = S_SHIFT;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (key_match) begin
                    n_res.hit       = 1'b1;
                    n_res.value_out = VALUE_W'(i_rd_data[VALUE_BITS-1:0]);
                    n_entry         = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        o_rd_addr = r_idx - IDX_W'(1);
                        n_idx     = r_idx - IDX_W'(1);
                        n_state   = S_SHIFT;
                    end
                end else if (r_idx == r_last) begin
                    n_state = S_DONE;
                end else begin
                    // read ahead one slot
                    o_rd_addr = r_idx + IDX_W'(1);
                    n_idx     = r_idx + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                // move each newer entry one slot older
                o_wr_en = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_PUT;
                end else begin
                    o_rd_addr = r_idx - IDX_W'(1);
                    n_idx     = r_idx - IDX_W'(1);
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = r_entry;
                if (r_ins) begin
                    n_held = r_held + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_key   <= n_key;
        r_entry <= n_entry;
        r_ins   <= n_ins;
        r_res   <= n_res;
    end

    assign o_res  = r_res;
    assign o_busy = (r_state != S_IDLE);
    assign o_held = r_held;

endmodule

FILE: tb/tb_lru_lookup_cache.sv
module tb_lru_lookup_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import lrc_pkg::*;

    localparam int ENTRIES = 1024;

    class lru_tracker;
        logic [KEY_W-1:0]   mru_keys[$];
        logic [VALUE_W-1:0] mru_values[$];
        t_out_res           expected_res[$];
        logic [CAP_W-1:0]   capacity = CAP_RESET;
        int                 errors = 0;
        int                 checked = 0;
        int                 hits = 0;
        int                 evictions = 0;

        function int effective_capacity();
            if (capacity == 0) return 1;
            if (capacity > ENTRIES) return ENTRIES;
            return int'(capacity);
        endfunction

        function int pending();
            return expected_res.size();
        endfunction

        function void note_request(t_in_req r);
            t_out_res           res;
            int                 cap;
            int                 i;
            logic [VALUE_W-1:0] val;
            res = '0;
            if (r.opcode == OP_LOOKUP) begin
                for (i = 0; i < mru_keys.size(); i++) begin
                    if (mru_keys[i] == r.key) begin
                        val = mru_values[i];
                        mru_keys.delete(i);
                        mru_values.delete(i);
                        mru_keys.push_front(r.key);
                        mru_values.push_front(val);
                        res.hit = 1'b1;
                        res.value_out = val;
                        break;
                    end
                end
            end else begin
                cap = effective_capacity();
                // drop the oldest entries so the new one brings the count to capacity
                if (mru_keys.size() >= cap) begin
                    res.evicted = 1'b1;
                    while (mru_keys.size() > cap - 1) begin
                        void'(mru_keys.pop_back());
                        void'(mru_values.pop_back());
                    end
                end
                mru_keys.push_front(r.key);
                mru_values.push_front(r.value);
            end
            expected_res.push_back(res);
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (expected_res.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hit=%0b value_out=%h evicted=%0b",
                         $time, got.hit, got.value_out, got.evicted);
                return;
            end
            want = expected_res.pop_front();
            checked++;
            if (want.hit) hits++;
            if (want.evicted) evictions++;
            if (got.hit !== want.hit) begin
                errors++;
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            end
            if (got.value_out !== want.value_out) begin
                errors++;
                $display("%0t: value_out expected %h actual %h",
                         $time, want.value_out, got.value_out);
            end
            if (got.evicted !== want.evicted) begin
                errors++;
                $display("%0t: evicted expected %0b actual %0b",
                         $time, want.evicted, got.evicted);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_req          i_in_req;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_res         o_out_res;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    lru_tracker       tracker = new();
    logic [KEY_W-1:0] inserted_keys[$];
    int               send_idle = 32;
    int               recv_idle = 61;
    int               hold_left = 0;
    logic             long_hold_req = 1'b0;

    lru_lookup_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("lru_lookup_cache test failed");
        $finish;
    end

    // result side: random stall, or one long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 400;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) tracker.check_result(o_out_res);
            if (i_in_valid && !o_in_stall) tracker.note_request(i_in_req);
        end
    end

    function automatic t_in_req make_req(logic op, logic [KEY_W-1:0] key,
                                         logic [VALUE_W-1:0] value);
        t_in_req r;
        r.opcode = op;
        r.key = key;
        r.value = value;
        return r;
    endfunction

    task automatic send_req(t_in_req r);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold requests until every expected result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.capacity = cap;
    endtask

    task automatic send_random();
        t_in_req r;
        int      pick;
        int      held;
        pick = $urandom_range(99);
        held = tracker.mru_keys.size();
        r.value = {$urandom, $urandom};
        if (pick < 45) begin
            r.opcode = OP_INSERT;
            if (held > 0 && $urandom_range(4) == 0)
                r.key = tracker.mru_keys[$urandom_range(held - 1)];
            else
                r.key = {$urandom, $urandom};
            inserted_keys.push_back(r.key);
        end else begin
            r.opcode = OP_LOOKUP;
            if (held > 0 && pick < 85)
                r.key = tracker.mru_keys[$urandom_range(held - 1)];
            else if (inserted_keys.size() > 0 && pick < 93)
                r.key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            else
                r.key = {$urandom, $urandom};
        end
        send_req(r);
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[6];
        phase_caps = '{11'd7, 11'd1, 11'd1024, 11'd16, 11'd2, 11'd37};

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty cache, duplicates, extreme keys and values at reset capacity
        send_req(make_req(OP_LOOKUP, 64'h0, 64'h0));
        send_req(make_req(OP_INSERT, 64'h0, '1));
        send_req(make_req(OP_INSERT, '1, 64'h0));
        send_req(make_req(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        send_req(make_req(OP_INSERT, 64'h0, 64'h1));
        send_req(make_req(OP_LOOKUP, 64'h0, 64'h0));
        send_req(make_req(OP_LOOKUP, '1, 64'h0));
        send_req(make_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '1));
        send_req(make_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        send_req(make_req(OP_LOOKUP, 64'h5555_5555_5555_5555, 64'h0));

        // capacity below the fill count: next insert trims to capacity
        drain();
        write_capacity(11'd3);
        send_req(make_req(OP_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
        send_req(make_req(OP_LOOKUP, 64'h0, 64'h0));
        send_req(make_req(OP_LOOKUP, '1, 64'h0));
        send_req(make_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0));

        // zero capacity acts as one
        drain();
        write_capacity(11'd0);
        send_req(make_req(OP_INSERT, 64'h1, 64'h2));
        send_req(make_req(OP_LOOKUP, 64'h1, 64'h0));
        send_req(make_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0));
        send_req(make_req(OP_INSERT, 64'h1, 64'h3));
        send_req(make_req(OP_LOOKUP, 64'h1, 64'h0));

        // oversized capacity saturates
        drain();
        write_capacity('1);
        send_req(make_req(OP_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
        send_req(make_req(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000));
        send_req(make_req(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0));
        send_req(make_req(OP_LOOKUP, 64'h1, 64'h0));

        for (int p = 0; p < 6; p++) begin
            send_idle = (p < 2) ? 32 : (p < 4) ? 61 : 0;
            recv_idle = (p < 2) ? 61 : (p < 4) ? 32 : 0;
            drain();
            write_capacity(phase_caps[p]);
            for (int k = 0; k < 92; k++) begin
                if (p == 4 && k == 5) long_hold_req = 1'b1;
                if (k == 46) drain();
                send_random();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);

        $display("%0d requests checked: %0d lookup hits, %0d inserts that evicted",
                 tracker.checked, tracker.hits, tracker.evictions);
        $display("capacities 0 to 2047 written, with long output hold-off and drains");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("lru_lookup_cache test passed");
        end else begin
            $display("lru_lookup_cache test failed");
        end
        $finish;
    end

endmodule
